// File: rtl/ppt_pkg.sv
// Shared constants and types for the projective point transform.
package ppt_pkg;

  localparam int ROW_WIDTH   = 64;
  localparam int LANE_STRIDE = 16;
  localparam int EPS_WIDTH   = 16;
  localparam int EPS_FRAC    = 16;
  localparam int ADDR_WIDTH  = 6;
  localparam int DATA_WIDTH  = 64;
  localparam int IDX_WIDTH   = 3;

  localparam logic [IDX_WIDTH-1:0] REG_ROW0 = 3'd0;
  localparam logic [IDX_WIDTH-1:0] REG_ROW1 = 3'd1;
  localparam logic [IDX_WIDTH-1:0] REG_ROW2 = 3'd2;
  localparam logic [IDX_WIDTH-1:0] REG_ROW3 = 3'd3;
  localparam logic [IDX_WIDTH-1:0] REG_EPS  = 3'd4;

  localparam logic [ROW_WIDTH-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
  localparam logic [ROW_WIDTH-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ROW_WIDTH-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
  localparam logic [ROW_WIDTH-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;
  localparam logic [EPS_WIDTH-1:0] EPS_RESET  = 16'd1;

  typedef struct packed {
    logic [3:0][ROW_WIDTH-1:0] rows;
    logic [EPS_WIDTH-1:0]      eps;
  } cfg_t;

endpackage

// File: rtl/projective_point_transform.sv
// Projective point transform: a point passes the product tree, the magnitude register and
// the divider stages. Throughput is one point per cycle while the output is not stalled,
// set by the fully pipelined multipliers and the bit-per-stage dividers. A stall at the output
// freezes the whole pipeline. Reset clears all valid bits, loads the identity matrix and epsilon 1.
module projective_point_transform
  import ppt_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_WIDTH-1:0]         paddr,
  input  logic [DATA_WIDTH-1:0]         pwdata,
  output logic [DATA_WIDTH-1:0]         prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          w_zero,
  output logic                          saturated
);

  localparam int CW      = COORD_WIDTH;
  localparam int FRAC    = CW / 2;
  localparam int ACC_W   = CW + COEF_WIDTH + 2;
  localparam int EPS_RAW = COEF_WIDTH - 4 + FRAC - EPS_FRAC;
  // A negative alignment leaves epsilon unshifted.
  localparam int EPS_SH  = (EPS_RAW > 0) ? EPS_RAW : 0;
  // Stages: three in the product tree, one for magnitudes, then the divider.
  localparam int DIV_LAT = CW + 3;
  localparam int D_IDX   = 3;
  localparam int TOTAL   = D_IDX + 1 + DIV_LAT;

  cfg_t cfg;
  logic en;

  logic [TOTAL-1:0]         vld;
  logic [3*CW-1:0]          pt   [0:TOTAL-1];
  logic [TOTAL-1:D_IDX]     wz;

  logic [3:0][ACC_W-1:0]    acc;
  logic [ACC_W-1:0]         nmag_c [3];
  logic                     nneg_c [3];
  logic [ACC_W-1:0]         wmag_c;
  logic                     wneg_c;
  logic [ACC_W-1:0]         eps_ext;

  logic [ACC_W-1:0]         nmag [3];
  logic                     qneg [3];
  logic [ACC_W-1:0]         wmag;

  logic [CW-1:0]            dres [3];
  logic                     dsat [3];

  ppt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The pipeline moves as one whenever the result register is empty or being taken.
  assign en        = !(vld[TOTAL-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], in_valid};
    end
  end

  // The input point travels alongside for the case where w is near zero.
  always_ff @(posedge clk) begin
    if (en) begin
      pt[0] <= {in_x, in_y, in_z};
      for (int i = 1; i < TOTAL; i++) begin
        pt[i] <= pt[i-1];
      end
    end
  end

  ppt_mac #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk  (clk),
    .en   (en),
    .x    (in_x),
    .y    (in_y),
    .z    (in_z),
    .rows (cfg.rows),
    .acc  (acc)
  );

  // Split every row sum into sign and magnitude, and test w against epsilon.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nneg_c[j] = acc[j][ACC_W-1];
      nmag_c[j] = nneg_c[j] ? (ACC_W'(0) - acc[j]) : acc[j];
    end
    wneg_c  = acc[3][ACC_W-1];
    wmag_c  = wneg_c ? (ACC_W'(0) - acc[3]) : acc[3];
    eps_ext = ACC_W'(cfg.eps) << EPS_SH;
  end

  // The near-zero flag is made here and then rides along with the divider stages.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        nmag[j] <= nmag_c[j];
        qneg[j] <= nneg_c[j] ^ wneg_c;
      end
      wmag      <= wmag_c;
      wz[D_IDX] <= eps_ext >= wmag_c;
      for (int i = D_IDX + 1; i < TOTAL; i++) begin
        wz[i] <= wz[i-1];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    ppt_div #(
      .COORD_WIDTH (COORD_WIDTH),
      .ACC_W       (ACC_W)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (nmag[j]),
      .den (wmag),
      .neg (qneg[j]),
      .res (dres[j]),
      .sat (dsat[j])
    );
  end

  // A near-zero w returns the original point and never reports saturation.
  always_comb begin
    w_zero    = wz[TOTAL-1];
    out_x     = w_zero ? pt[TOTAL-1][3*CW-1:2*CW] : dres[0];
    out_y     = w_zero ? pt[TOTAL-1][2*CW-1:CW]   : dres[1];
    out_z     = w_zero ? pt[TOTAL-1][CW-1:0]      : dres[2];
    saturated = !w_zero && (dsat[0] || dsat[1] || dsat[2]);
  end

endmodule

// File: rtl/ppt_cfg.sv
// Configuration register file behind the APB-style port.
module ppt_cfg
  import ppt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [IDX_WIDTH-1:0] idx;
  logic                 wr;

  assign idx    = paddr[ADDR_WIDTH-1:3];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows[0] <= ROW0_RESET;
      cfg.rows[1] <= ROW1_RESET;
      cfg.rows[2] <= ROW2_RESET;
      cfg.rows[3] <= ROW3_RESET;
      cfg.eps     <= EPS_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_ROW0: cfg.rows[0] <= pwdata;
        REG_ROW1: cfg.rows[1] <= pwdata;
        REG_ROW2: cfg.rows[2] <= pwdata;
        REG_ROW3: cfg.rows[3] <= pwdata;
        REG_EPS:  cfg.eps     <= pwdata[EPS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROW0: prdata = cfg.rows[0];
      REG_ROW1: prdata = cfg.rows[1];
      REG_ROW2: prdata = cfg.rows[2];
      REG_ROW3: prdata = cfg.rows[3];
      REG_EPS:  prdata = DATA_WIDTH'(cfg.eps);
      default:  prdata = '0;
    endcase
  end

endmodule

// File: rtl/ppt_mac.sv
// Matrix-vector product: registered multipliers followed by a two-level adder tree.
module ppt_mac
  import ppt_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16,
  parameter int ACC_W       = COORD_WIDTH + COEF_WIDTH + 2
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  input  logic signed [COORD_WIDTH-1:0] z,
  input  logic [3:0][ROW_WIDTH-1:0]     rows,
  output logic [3:0][ACC_W-1:0]         acc
);

  localparam int FRAC  = COORD_WIDTH / 2;
  localparam int EXT_W = ROW_WIDTH + COEF_WIDTH;
  localparam int PW    = COORD_WIDTH + COEF_WIDTH;

  logic [EXT_W-1:0]             row_ext [4];
  logic signed [COEF_WIDTH-1:0] coef    [4][4];
  logic signed [PW-1:0]         prod_c  [4][3];
  logic signed [ACC_W-1:0]      prod    [4][4];
  logic signed [ACC_W-1:0]      s01     [4];
  logic signed [ACC_W-1:0]      s23     [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      row_ext[r] = {{COEF_WIDTH{1'b0}}, rows[r]};
      for (int j = 0; j < 4; j++) begin
        coef[r][j] = row_ext[r][LANE_STRIDE*j +: COEF_WIDTH];
      end
      prod_c[r][0] = x * coef[r][0];
      prod_c[r][1] = y * coef[r][1];
      prod_c[r][2] = z * coef[r][2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod[r][j] <= ACC_W'(prod_c[r][j]);
        end
        // The homogeneous coordinate is 1.0, so its term is a shifted coefficient.
        prod[r][3] <= ACC_W'(coef[r][3]) <<< FRAC;
        s01[r] <= prod[r][0] + prod[r][1];
        s23[r] <= prod[r][2] + prod[r][3];
        acc[r] <= s01[r] + s23[r];
      end
    end
  end

endmodule

// File: rtl/ppt_div.sv
// Pipelined restoring divider, one quotient bit per stage, with rounding and saturation.
module ppt_div #(
  parameter int COORD_WIDTH = 32,
  parameter int ACC_W       = 50
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ACC_W-1:0]       num,
  input  logic [ACC_W-1:0]       den,
  input  logic                   neg,
  output logic [COORD_WIDTH-1:0] res,
  output logic                   sat
);

  localparam int CW   = COORD_WIDTH;
  localparam int FRAC = CW / 2;
  localparam int NW   = ACC_W + FRAC;
  localparam int HI_W = NW - CW;

  logic [NW-1:0]    nshift;
  logic [HI_W-1:0]  hi;
  logic             ovf0;

  logic [ACC_W-1:0] rem_q [0:CW];
  logic [CW-1:0]    lo_q  [0:CW];
  logic [CW-1:0]    quo_q [0:CW];
  logic [ACC_W-1:0] den_q [0:CW];
  logic             neg_q [0:CW];
  logic             ovf_q [0:CW];

  logic [CW:0]      qr;
  logic             rneg;
  logic             rovf;
  logic             rnd;
  logic [CW:0]      maxmag;
  logic             sat_c;
  logic [CW:0]      mag;

  assign nshift = {num, {FRAC{1'b0}}};
  assign hi     = nshift[NW-1:CW];
  assign ovf0   = ACC_W'(hi) >= den;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= ovf0 ? '0 : ACC_W'(hi);
      lo_q[0]  <= nshift[CW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den;
      neg_q[0] <= neg;
      ovf_q[0] <= ovf0;
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_bit
    logic [ACC_W:0] trial;
    logic [ACC_W:0] diff;
    logic           ge;

    always_comb begin
      trial = {rem_q[k], lo_q[k][CW-1]};
      diff  = trial - {1'b0, den_q[k]};
      ge    = trial >= {1'b0, den_q[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
        lo_q[k+1]  <= lo_q[k] << 1;
        quo_q[k+1] <= {quo_q[k][CW-2:0], ge};
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign rnd = {rem_q[CW], 1'b0} >= {1'b0, den_q[CW]};

  always_ff @(posedge clk) begin
    if (en) begin
      qr   <= {1'b0, quo_q[CW]} + (CW+1)'(rnd);
      rneg <= neg_q[CW];
      rovf <= ovf_q[CW];
    end
  end

  always_comb begin
    maxmag = (CW+1)'(1) << (CW - 1);
    if (!rneg) begin
      maxmag = maxmag - (CW+1)'(1);
    end
    sat_c = rovf || (qr > maxmag);
    mag   = sat_c ? maxmag : qr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= rneg ? CW'(-mag) : CW'(mag);
      sat <= sat_c;
    end
  end

endmodule

// File: sim/projective_point_transform_tb.sv
// Self-checking testbench for the projective point transform with perspective divide.
`timescale 1ns / 100ps

module projective_point_transform_tb;
  import ppt_pkg::*;

  localparam int CW = 32;
  localparam int LATENCY = CW + 7;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 wz;
    logic                 sat;
  } point_result_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    bit                   typed;
    point_result_t        res;
  } stim_row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [DATA_WIDTH-1:0] pwdata;
  logic [DATA_WIDTH-1:0] prdata;
  logic pready;
  logic in_valid, in_stall;
  logic signed [CW-1:0] in_x, in_y, in_z;
  logic out_valid, out_stall;
  logic signed [CW-1:0] out_x, out_y, out_z;
  logic w_zero, saturated;

  projective_point_transform i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .w_zero(w_zero), .saturated(saturated)
  );

  // Shadow copy of the matrix rows and epsilon, kept in step with every write.
  logic [ROW_WIDTH-1:0] mat_rows [4];
  logic [EPS_WIDTH-1:0] eps_shadow;

  point_result_t pending_points [$];
  int  error_count = 0;
  longint cycle_count = 0;
  bit  sender_quiet = 0;
  bit  receiver_quiet = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // The run is bounded no matter what the block does.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Rounded, saturated quotient (num << 16) / den with den > 0, ties away from zero.
  function automatic logic [CW-1:0] divide_round(input logic [127:0] num,
                                                  input logic [127:0] den,
                                                  input bit neg, inout bit sat);
    logic [255:0] scaled;
    logic [255:0] quot;
    logic [255:0] rem;
    logic [255:0] maxmag;
    scaled = {128'b0, num} << (CW / 2);
    quot = scaled / den;
    rem = scaled % den;
    if ((rem << 1) >= den) quot = quot + 1;
    maxmag = (256'd1 << (CW - 1)) - (neg ? 0 : 1);
    if (quot > maxmag) begin
      sat = 1;
      quot = maxmag;
    end
    return neg ? (CW'(0) - quot[CW-1:0]) : quot[CW-1:0];
  endfunction

  // Projects one point through the shadow matrix and divides by w.
  function automatic point_result_t project_point(input logic signed [CW-1:0] px,
                                                  input logic signed [CW-1:0] py,
                                                  input logic signed [CW-1:0] pz);
    logic signed [127:0] vec [4];
    logic signed [127:0] acc [4];
    logic signed [15:0]  coef;
    logic [127:0] mag_w, mag_n, eps_wide;
    point_result_t res;
    bit sat;
    logic [CW-1:0] q [3];
    vec[0] = px;
    vec[1] = py;
    vec[2] = pz;
    vec[3] = 128'sd1 <<< (CW / 2);
    for (int r = 0; r < 4; r++) begin
      acc[r] = 0;
      for (int j = 0; j < 4; j++) begin
        coef = mat_rows[r][LANE_STRIDE*j +: 16];
        acc[r] = acc[r] + vec[j] * 128'(coef);
      end
    end
    mag_w = acc[3][127] ? -acc[3] : acc[3];
    // Epsilon has 16 fraction bits; accumulators have 28.
    eps_wide = 128'(eps_shadow) << 12;
    sat = 0;
    if (mag_w <= eps_wide) begin
      res.x = px;
      res.y = py;
      res.z = pz;
      res.wz = 1;
      res.sat = 0;
      return res;
    end
    for (int j = 0; j < 3; j++) begin
      mag_n = acc[j][127] ? -acc[j] : acc[j];
      q[j] = divide_round(mag_n, mag_w, acc[j][127] ^ acc[3][127], sat);
    end
    res.x = q[0];
    res.y = q[1];
    res.z = q[2];
    res.wz = 0;
    res.sat = sat;
    return res;
  endfunction

  // Register write over the APB-style port; only called while the block is drained.
  task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [63:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= ADDR_WIDTH'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_ROW0: mat_rows[0] = value;
      REG_ROW1: mat_rows[1] = value;
      REG_ROW2: mat_rows[2] = value;
      REG_ROW3: mat_rows[3] = value;
      REG_EPS:  eps_shadow = value[EPS_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic load_matrix(input logic [63:0] r0, input logic [63:0] r1,
                             input logic [63:0] r2, input logic [63:0] r3,
                             input logic [15:0] eps);
    write_reg(REG_ROW0, r0);
    write_reg(REG_ROW1, r1);
    write_reg(REG_ROW2, r2);
    write_reg(REG_ROW3, r3);
    write_reg(REG_EPS, {48'b0, eps});
  endtask

  // Stops sending and waits for the pipeline to empty before the configuration may change.
  task automatic drain_pipeline();
    in_valid <= 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Presents one point and holds it until the transfer happens.
  task automatic send_point(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
                            input logic signed [CW-1:0] pz, input bit typed,
                            input point_result_t typed_res);
    point_result_t res;
    while (!sender_quiet && $urandom_range(99) < 6) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_x <= px;
    in_y <= py;
    in_z <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = typed ? typed_res : project_point(px, py, pz);
    pending_points.push_back(res);
  endtask

  // The receiver stalls at random except during the quiet stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      out_stall <= !receiver_quiet && ($urandom_range(99) < 6);
    end
  end

  // Each result transfer is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    point_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("unexpected result x=%h y=%h z=%h", out_x, out_y, out_z);
        error_count++;
      end else begin
        exp_res = pending_points.pop_front();
        if (out_x !== exp_res.x) begin
          $error("out_x expected %h actual %h", exp_res.x, out_x);
          error_count++;
        end
        if (out_y !== exp_res.y) begin
          $error("out_y expected %h actual %h", exp_res.y, out_y);
          error_count++;
        end
        if (out_z !== exp_res.z) begin
          $error("out_z expected %h actual %h", exp_res.z, out_z);
          error_count++;
        end
        if (w_zero !== exp_res.wz) begin
          $error("w_zero expected %b actual %b", exp_res.wz, w_zero);
          error_count++;
        end
        if (saturated !== exp_res.sat) begin
          $error("saturated expected %b actual %b", exp_res.sat, saturated);
          error_count++;
        end
      end
    end
  end

  function automatic logic [15:0] random_coef();
    case ($urandom_range(5))
      0: return 16'h1000;
      1: return 16'hF000;
      2: return 16'h0000;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(8191)) - 4096);
    endcase
  endfunction

  function automatic logic signed [CW-1:0] random_coord();
    case ($urandom_range(5))
      0: return CW'($urandom);
      1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return CW'($signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  stim_row_t directed_rows [$];

  function automatic stim_row_t row_of(input logic signed [CW-1:0] px,
                                       input logic signed [CW-1:0] py,
                                       input logic signed [CW-1:0] pz, input bit typed,
                                       input logic wz, input logic sat,
                                       input logic signed [CW-1:0] ex,
                                       input logic signed [CW-1:0] ey,
                                       input logic signed [CW-1:0] ez);
    stim_row_t row;
    row.x = px;
    row.y = py;
    row.z = pz;
    row.typed = typed;
    row.res.x = ex;
    row.res.y = ey;
    row.res.z = ez;
    row.res.wz = wz;
    row.res.sat = sat;
    return row;
  endfunction

  initial begin
    logic [63:0] r [4];
    logic [15:0] eps_val;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_valid = 0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    mat_rows[0] = ROW0_RESET;
    mat_rows[1] = ROW1_RESET;
    mat_rows[2] = ROW2_RESET;
    mat_rows[3] = ROW3_RESET;
    eps_shadow = EPS_RESET;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // After reset the identity matrix passes points through untouched.
    directed_rows.push_back(row_of(0, 0, 0, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(row_of(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, 1, 0, 0,
                                   32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000));
    directed_rows.push_back(row_of(-1, 1, 32'sh5555_AAAA, 1, 0, 0, -1, 1, 32'sh5555_AAAA));
    foreach (directed_rows[i])
      send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                 directed_rows[i].typed, directed_rows[i].res);
    drain_pipeline();

    // A zero bottom row makes w exactly zero: every point passes through flagged.
    directed_rows.delete();
    load_matrix(ROW0_RESET, ROW1_RESET, ROW2_RESET, 64'h0, 16'h0);
    directed_rows.push_back(row_of(32'sh1234_5678, -5, 32'sh7FFF_FFFF, 1, 1, 0,
                                   32'sh1234_5678, -5, 32'sh7FFF_FFFF));
    directed_rows.push_back(row_of(32'sh8000_0000, 0, 0, 1, 1, 0, 32'sh8000_0000, 0, 0));
    foreach (directed_rows[i])
      send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                 directed_rows[i].typed, directed_rows[i].res);
    drain_pipeline();

    // Largest coefficients with a tiny w drive the quotients into saturation;
    // the largest epsilon then counts small w as zero.
    load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, 64'h0,
                64'h0001_0000_0000_0001, 16'h0);
    directed_rows.delete();
    directed_rows.push_back(row_of(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0,
                                   0, 0, 0));
    directed_rows.push_back(row_of(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0,
                                   0, 0, 0));
    directed_rows.push_back(row_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row_of(-32'sh0001_0000, 32'sh10, 1, 0, 0, 0, 0, 0, 0));
    foreach (directed_rows[i])
      send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                 directed_rows[i].typed, directed_rows[i].res);
    drain_pipeline();
    write_reg(REG_EPS, 64'hFFFF);
    // An unknown register index must be ignored by the block.
    write_reg(3'd7, 64'hDEAD_BEEF_0000_0000);
    foreach (directed_rows[i])
      send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                 directed_rows[i].typed, directed_rows[i].res);
    drain_pipeline();

    // Random phases: a fresh matrix each time, mostly moderate coefficients.
    for (int phase = 0; phase < 8; phase++) begin
      for (int k = 0; k < 4; k++)
        r[k] = {random_coef(), random_coef(), random_coef(), random_coef()};
      // Keep w comfortably positive in most phases so quotients stay in range.
      if (phase % 4 != 3) r[3][63:48] = 16'h1000;
      eps_val = (phase == 5) ? 16'hFFFF : (phase == 6 ? 16'h0 : 16'($urandom));
      load_matrix(r[0], r[1], r[2], r[3], eps_val);
      sender_quiet = (phase == 2);
      receiver_quiet = (phase == 2);
      for (int n = 0; n < 50; n++) begin
        send_point(random_coord(), random_coord(), random_coord(), 0, '{default: 0});
      end
      // The sender holds off here until every outstanding result is back.
      drain_pipeline();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && pending_points.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
